// ===== src/ezr_pkg.sv =====
// shared types, constants and fixed-point helpers for the euler z-x-z rotation matrix
// no dependencies
`default_nettype none
package ezr_pkg;

    typedef logic signed [31:0] q30_t;

    localparam logic signed [35:0] PI_HALF_Q32 = 36'sd6746518852;
    localparam logic signed [31:0] QONE        = 32'sh4000_0000;
    localparam int                 NTERMS      = 5;

    // reciprocals of the odd parts of the horner divisors, ceil(2^post / odd)
    localparam logic [63:0] SM0 = ((64'd1 << 35) + 64'd54) / 64'd55;
    localparam logic [63:0] SM1 = ((64'd1 << 31) + 64'd8) / 64'd9;
    localparam logic [63:0] SM2 = ((64'd1 << 34) + 64'd20) / 64'd21;
    localparam logic [63:0] SM3 = ((64'd1 << 31) + 64'd4) / 64'd5;
    localparam logic [63:0] SM4 = ((64'd1 << 31) + 64'd2) / 64'd3;
    localparam logic [63:0] CM0 = ((64'd1 << 35) + 64'd44) / 64'd45;
    localparam logic [63:0] CM1 = ((64'd1 << 30) + 64'd6) / 64'd7;
    localparam logic [63:0] CM2 = ((64'd1 << 33) + 64'd14) / 64'd15;
    localparam logic [63:0] CM3 = ((64'd1 << 30) + 64'd2) / 64'd3;

    typedef struct packed {
        logic [1:0] quad;
        q30_t       x;
    } red_t;

    typedef struct packed {
        q30_t s;
        q30_t c;
    } sc_t;

    // floor(n / d) for the sine divisors 110, 72, 42, 20, 6 with n below 2^30
    function automatic logic [31:0] sdiv_q(input int idx, input logic [29:0] n);
        logic [63:0] p;
        begin
            case (idx)
                0: p = (64'(n[29:1]) * SM0) >> 35;
                1: p = (64'(n[29:3]) * SM1) >> 31;
                2: p = (64'(n[29:1]) * SM2) >> 34;
                3: p = (64'(n[29:2]) * SM3) >> 31;
                default: p = (64'(n[29:1]) * SM4) >> 31;
            endcase
            return p[31:0];
        end
    endfunction

    // floor(n / d) for the cosine divisors 90, 56, 30, 12, 2 with n below 2^30
    function automatic logic [31:0] cdiv_q(input int idx, input logic [29:0] n);
        logic [63:0] p;
        begin
            case (idx)
                0: p = (64'(n[29:1]) * CM0) >> 35;
                1: p = (64'(n[29:3]) * CM1) >> 30;
                2: p = (64'(n[29:1]) * CM2) >> 33;
                3: p = (64'(n[29:2]) * CM3) >> 30;
                default: p = 64'(n[29:1]);
            endcase
            return p[31:0];
        end
    endfunction

    // floor(a*b / 2^30)
    function automatic q30_t qmul(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        begin
            p = a * b;
            return p[61:30];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/ezr_sincos.sv =====
// pipelined polynomial sine and cosine of one turn-fraction angle
// depends on ezr_pkg
`default_nettype none
module ezr_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output ezr_pkg::sc_t               sc
);
    localparam int NST = ezr_pkg::NTERMS;
    localparam int NP  = 2 * NST;

    logic [1:0]        q0_reg;
    logic signed [31:0] r0_reg;
    logic [1:0]        q1_reg;
    ezr_pkg::q30_t     x1_reg;
    logic [1:0]        q2_reg;
    ezr_pkg::q30_t     x2_reg, xs2_reg;
    logic [1:0]        qp_reg [NP+1];
    ezr_pkg::q30_t     xp_reg [NP+1];
    ezr_pkg::q30_t     x2p_reg [NP-1];
    ezr_pkg::q30_t     hs_reg [NST+1];
    ezr_pkg::q30_t     hc_reg [NST+1];
    logic [29:0]       ms_reg [NST];
    logic [29:0]       mc_reg [NST];

    logic [31:0]        t;
    logic [1:0]         qn;
    logic signed [67:0] xprod;

    always_comb
    begin
        t     = 32'(angle) << (32 - ANGLE_BITS);
        qn    = 2'((t + 32'h2000_0000) >> 30);
        xprod = 68'(r0_reg) * 68'(ezr_pkg::PI_HALF_Q32) + 68'sh8000_0000;
    end

    // each horner step: product stage, then reciprocal divide and subtract stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg  <= qn;
            r0_reg  <= signed'(t - {qn, 30'd0});
            q1_reg  <= q0_reg;
            x1_reg  <= xprod[63:32];
            q2_reg  <= q1_reg;
            xs2_reg <= x1_reg;
            x2_reg  <= ezr_pkg::qmul(x1_reg, x1_reg);
            qp_reg[0]  <= q2_reg;
            xp_reg[0]  <= xs2_reg;
            x2p_reg[0] <= x2_reg;
            hs_reg[0]  <= ezr_pkg::QONE;
            hc_reg[0]  <= ezr_pkg::QONE;
            for (int i = 0; i < NP; i++)
            begin
                qp_reg[i+1] <= qp_reg[i];
                xp_reg[i+1] <= xp_reg[i];
            end
            for (int i = 0; i < NP - 2; i++)
                x2p_reg[i+1] <= x2p_reg[i];
            for (int i = 0; i < NST; i++)
            begin
                ms_reg[i]   <= 30'(ezr_pkg::qmul(x2p_reg[2*i], hs_reg[i]));
                mc_reg[i]   <= 30'(ezr_pkg::qmul(x2p_reg[2*i], hc_reg[i]));
                hs_reg[i+1] <= ezr_pkg::QONE - signed'(ezr_pkg::sdiv_q(i, ms_reg[i]));
                hc_reg[i+1] <= ezr_pkg::QONE - signed'(ezr_pkg::cdiv_q(i, mc_reg[i]));
            end
        end
    end

    ezr_pkg::q30_t s_reg, c_reg;
    logic [1:0]    qf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg  <= ezr_pkg::qmul(xp_reg[NP], hs_reg[NST]);
            c_reg  <= hc_reg[NST];
            qf_reg <= qp_reg[NP];
        end
    end

    always_comb
    begin
        case (qf_reg)
            2'd0: begin sc.s = s_reg;  sc.c = c_reg;  end
            2'd1: begin sc.s = c_reg;  sc.c = -s_reg; end
            2'd2: begin sc.s = -s_reg; sc.c = -c_reg; end
            default: begin sc.s = -c_reg; sc.c = s_reg; end
        endcase
    end

    logic unused;
    assign unused = rst_n;
endmodule
`default_nettype wire

// ===== src/euler_zxz_rotation_matrix_top.sv =====
// euler z-x-z rotation matrix, top level
// depends on ezr_pkg and ezr_sincos
//
// channel | dir | contents
// s_axis  | in  | tdata: angle_phi, angle_theta, angle_psi
// m_axis  | out | tdata: r11 r12 r13 r21 r22 r23 r31 r32 r33
//
// one transaction per cycle unless the output stalls, LAT = 18 register stages from input to result
// depth set by the five horner steps of the sine/cosine unit, two stages each, its
// five other stages, the two product stages and the output stage
// the whole pipe advances when the output register is free or taken
// reset clears the valid bits only
`default_nettype none
module euler_zxz_rotation_matrix_top #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // angle_phi, angle_theta, angle_psi
    input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // r11 r12 r13 r21 r22 r23 r31 r32 r33
    output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
    localparam int OW  = FRAC_BITS + 2;
    localparam int K   = 30 - FRAC_BITS;
    localparam int SCL = 2 * ezr_pkg::NTERMS + 5;
    localparam int LAT = SCL + 3;
    localparam int DW  = ((9*OW+7)/8)*8;
    localparam logic signed [32:0] RND = (33'sd1 <<< K) >>> 1;

    logic [LAT-1:0] v_reg;
    logic           en;

    assign en            = !v_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[LAT-2:0], s_axis_tvalid};
    end

    ezr_pkg::sc_t ph, th, ps;

    ezr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_phi (.clk(clk), .rst_n(rst_n), .en(en),
        .angle(s_axis_tdata[ANGLE_BITS-1:0]), .sc(ph));
    ezr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_theta (.clk(clk), .rst_n(rst_n), .en(en),
        .angle(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .sc(th));
    ezr_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_psi (.clk(clk), .rst_n(rst_n), .en(en),
        .angle(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]), .sc(ps));

    // stage a: two-factor products
    ezr_pkg::q30_t cc_reg, cs_reg, pcc_reg, pcs_reg, psc_reg, pss_reg;
    ezr_pkg::q30_t r13a_reg, r23a_reg, r31a_reg, r32a_reg, r33a_reg, pss2_reg, psc2_reg;
    // stage b: three-factor products
    ezr_pkg::q30_t e_reg [9];
    ezr_pkg::q30_t t1_reg, t2_reg, t3_reg, t4_reg;
    logic [OW-1:0] o_reg [9];

    function automatic logic [OW-1:0] to_out(input ezr_pkg::q30_t e);
        logic signed [32:0] v;
        begin
            if (K > 0)
                v = (33'(e) + RND) >>> K;
            else
                v = 33'(e);
            if (v > 33'sd1 <<< FRAC_BITS)
                v = 33'sd1 <<< FRAC_BITS;
            if (v < -(33'sd1 <<< FRAC_BITS))
                v = -(33'sd1 <<< FRAC_BITS);
            return v[OW-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg   <= ezr_pkg::qmul(th.c, ph.c);
            cs_reg   <= ezr_pkg::qmul(th.c, ph.s);
            pcc_reg  <= ezr_pkg::qmul(ps.c, ph.c);
            pcs_reg  <= ezr_pkg::qmul(ps.c, ph.s);
            psc_reg  <= ezr_pkg::qmul(ps.s, ph.c);
            pss_reg  <= ezr_pkg::qmul(ps.s, ph.s);
            r13a_reg <= ezr_pkg::qmul(ps.s, th.s);
            r23a_reg <= ezr_pkg::qmul(ps.c, th.s);
            r31a_reg <= ezr_pkg::qmul(th.s, ph.s);
            r32a_reg <= -ezr_pkg::qmul(th.s, ph.c);
            r33a_reg <= th.c;
            pss2_reg <= ps.s;
            psc2_reg <= ps.c;

            t1_reg   <= ezr_pkg::qmul(cs_reg, pss2_reg);
            t2_reg   <= ezr_pkg::qmul(cc_reg, pss2_reg);
            t3_reg   <= ezr_pkg::qmul(cs_reg, psc2_reg);
            t4_reg   <= ezr_pkg::qmul(cc_reg, psc2_reg);
            e_reg[0] <= pcc_reg;
            e_reg[1] <= pcs_reg;
            e_reg[2] <= r13a_reg;
            e_reg[3] <= -psc_reg;
            e_reg[4] <= -pss_reg;
            e_reg[5] <= r23a_reg;
            e_reg[6] <= r31a_reg;
            e_reg[7] <= r32a_reg;
            e_reg[8] <= r33a_reg;

            o_reg[0] <= to_out(e_reg[0] - t1_reg);
            o_reg[1] <= to_out(e_reg[1] + t2_reg);
            o_reg[2] <= to_out(e_reg[2]);
            o_reg[3] <= to_out(e_reg[3] - t3_reg);
            o_reg[4] <= to_out(e_reg[4] + t4_reg);
            o_reg[5] <= to_out(e_reg[5]);
            o_reg[6] <= to_out(e_reg[6]);
            o_reg[7] <= to_out(e_reg[7]);
            o_reg[8] <= to_out(e_reg[8]);
        end
    end

    always_comb
    begin
        m_axis_tdata = '0;
        for (int i = 0; i < 9; i++)
            m_axis_tdata[i*OW +: OW] = o_reg[i];
    end

    logic unused;
    assign unused = ^{s_axis_tdata, DW[0]};
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for euler_zxz_rotation_matrix_top
// depends on ezr_pkg and the top level; predicts each matrix from the three angles
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = ((3*ANGLE_BITS+7)/8)*8;
    localparam int EW         = FRAC_BITS + 2;
    localparam int OUT_W      = ((9*EW+7)/8)*8;
    localparam int LIMIT      = 2000;

    typedef logic signed [EW-1:0] entry_t;
    typedef struct {
        entry_t e [9];
    } matrix_t;
    typedef struct {
        longint s;
        longint c;
    } trig_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    matrix_t matrix_queue[$];
    int      errors;
    int      idle_cycles;
    bit      sending_done;

    euler_zxz_rotation_matrix_top #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_sh(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return floor_sh(a * b, 30);
    endfunction

    function automatic trig_t angle_trig(logic [ANGLE_BITS-1:0] angle);
        longint sd[5] = '{110, 72, 42, 20, 6};
        longint cd[5] = '{90, 56, 30, 12, 2};
        logic [31:0] t;
        logic [1:0]  q;
        logic [31:0] ru;
        longint r, x, x2, hs, hc, s, c;
        trig_t o;
        t = 32'(angle) << (32 - ANGLE_BITS);
        q = 2'((t + 32'h2000_0000) >> 30);
        ru = t - (32'(q) << 30);
        r = longint'($signed(ru));
        x = floor_sh(r * 64'sd6746518852 + (64'sd1 << 31), 32);
        x2 = q30_mul(x, x);
        hs = 64'sd1 << 30;
        hc = 64'sd1 << 30;
        for (int i = 0; i < 5; i++)
        begin
            hs = (64'sd1 << 30) - q30_mul(x2, hs) / sd[i];
            hc = (64'sd1 << 30) - q30_mul(x2, hc) / cd[i];
        end
        s = q30_mul(x, hs);
        c = hc;
        case (q)
            2'd0: begin o.s = s;  o.c = c;  end
            2'd1: begin o.s = c;  o.c = -s; end
            2'd2: begin o.s = -s; o.c = -c; end
            default: begin o.s = -c; o.c = s; end
        endcase
        return o;
    endfunction

    function automatic entry_t to_entry(longint e);
        int k = 30 - FRAC_BITS;
        longint lim = 64'sd1 << FRAC_BITS;
        longint v = e;
        if (k > 0)
            v = floor_sh(e + (64'sd1 << (k - 1)), k);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return entry_t'(v);
    endfunction

    function automatic matrix_t rotation_of(logic [ANGLE_BITS-1:0] phi,
                                           logic [ANGLE_BITS-1:0] theta,
                                           logic [ANGLE_BITS-1:0] psi);
        trig_t ph, th, ps;
        matrix_t m;
        ph = angle_trig(phi);
        th = angle_trig(theta);
        ps = angle_trig(psi);
        m.e[0] = to_entry(q30_mul(ps.c, ph.c) - q30_mul(q30_mul(th.c, ph.s), ps.s));
        m.e[1] = to_entry(q30_mul(ps.c, ph.s) + q30_mul(q30_mul(th.c, ph.c), ps.s));
        m.e[2] = to_entry(q30_mul(ps.s, th.s));
        m.e[3] = to_entry(-q30_mul(ps.s, ph.c) - q30_mul(q30_mul(th.c, ph.s), ps.c));
        m.e[4] = to_entry(-q30_mul(ps.s, ph.s) + q30_mul(q30_mul(th.c, ph.c), ps.c));
        m.e[5] = to_entry(q30_mul(ps.c, th.s));
        m.e[6] = to_entry(q30_mul(th.s, ph.s));
        m.e[7] = to_entry(-q30_mul(th.s, ph.c));
        m.e[8] = to_entry(th.c);
        return m;
    endfunction

    task automatic send_angles(logic [ANGLE_BITS-1:0] phi, logic [ANGLE_BITS-1:0] theta,
                               logic [ANGLE_BITS-1:0] psi);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({psi, theta, phi});
        do
            @(posedge clk);
        while (!s_axis_tready);
        matrix_queue.push_back(rotation_of(phi, theta, psi));
    endtask

    // stalls on the result side
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        matrix_t exp_m;
        entry_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (matrix_queue.size() == 0)
            begin
                $error("unexpected transaction on m_axis");
                errors++;
            end
            else
            begin
                exp_m = matrix_queue.pop_front();
                for (int i = 0; i < 9; i++)
                begin
                    got = m_axis_tdata[i*EW +: EW];
                    if (got !== exp_m.e[i])
                    begin
                        $error("r%0d%0d expected %0d actual %0d",
                               i / 3 + 1, i % 3 + 1, exp_m.e[i], got);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on transactions
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT && !sending_done)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_extremes();
        logic [ANGLE_BITS-1:0] v[6] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                       16'h2000};
        for (int i = 0; i < 6; i++)
            send_angles(v[i], v[(i + 1) % 6], v[(i + 3) % 6]);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(16'h5555, 16'hAAAA, 16'h5555);
    endtask

    task automatic test_overshoot_and_wrap();
        logic [ANGLE_BITS-1:0] v[8] = '{16'h1FFF, 16'h2001, 16'h3FFF, 16'h4001, 16'h7FFF,
                                       16'h8001, 16'hDFFF, 16'hE000};
        for (int i = 0; i < 8; i++)
            send_angles(v[i], v[7 - i], v[(i + 2) % 8]);
    endtask

    task automatic test_random();
        for (int i = 0; i < 1900; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                send_angles(16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 3)) - 16'd1,
                            16'($urandom), 16'(-$urandom_range(0, 2)));
            else
                send_angles(16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        int waited;
        errors = 0;
        idle_cycles = 0;
        sending_done = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_overshoot_and_wrap();
        test_random();
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (matrix_queue.size() != 0 && waited < 100 * LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        sending_done = 1'b1;
        repeat (40) @(posedge clk);
        if (errors == 0 && matrix_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== euler_zxz_rotation_matrix_top.f =====
src/ezr_pkg.sv
src/ezr_sincos.sv
src/euler_zxz_rotation_matrix_top.sv
sim/testbench.sv
